FILE: rtl/mecanum_wheel_odometry_defines.svh
// Assertion macros used by the odometry top level.
`ifndef MECANUM_WHEEL_ODOMETRY_DEFINES_SVH
`define MECANUM_WHEEL_ODOMETRY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MWO_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MWO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mwo_pkg.sv
// Types, constants and helper functions for the mecanum odometry block.
`timescale 1ns / 1ps
package mwo_pkg;

	localparam int WHEEL_COUNT = 4;

	localparam logic [1:0] REG_SPEED_GAIN   = 2'd0;
	localparam logic [1:0] REG_RIM_RADIUS   = 2'd1;
	localparam logic [1:0] REG_INV_HALF_SUM = 2'd2;

	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	typedef struct packed {
		logic              mode;
		logic [1:0]        wheel_index;
		logic signed [31:0] abs_count;
		logic [15:0]       time_step;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] yaw_rate;
		logic [30:0]        speed_magnitude;
	} pose_t;

	typedef struct packed {
		logic [31:0] speed_gain;
		logic [15:0] rim_radius;
		logic [23:0] inv_half_base_sum;
	} cfg_t;

	typedef struct packed {
		logic    avail;
		sample_t entry;
	} q_head_t;

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		if (v > 67'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -67'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: return 32'd843314856;
			5'd1: return 32'd497837829;
			5'd2: return 32'd263043836;
			5'd3: return 32'd133525158;
			5'd4: return 32'd67021686;
			5'd5: return 32'd33543515;
			5'd6: return 32'd16775850;
			5'd7: return 32'd8388437;
			5'd8: return 32'd4194282;
			5'd9: return 32'd2097149;
			5'd10: return 32'd1048575;
			5'd11: return 32'd524287;
			5'd12: return 32'd262143;
			5'd13: return 32'd131071;
			5'd14: return 32'd65535;
			5'd15: return 32'd32767;
			5'd16: return 32'd16383;
			5'd17: return 32'd8191;
			5'd18: return 32'd4095;
			5'd19: return 32'd2047;
			5'd20: return 32'd1023;
			5'd21: return 32'd511;
			5'd22: return 32'd255;
			5'd23: return 32'd127;
			5'd24: return 32'd63;
			5'd25: return 32'd31;
			5'd26: return 32'd15;
			5'd27: return 32'd8;
			5'd28: return 32'd4;
			5'd29: return 32'd2;
			5'd30: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction

endpackage

FILE: rtl/mecanum_wheel_odometry.sv
// Top level: configuration registers, front queue, back sequencer and result register.
//
// channel   direction  handshake                   payload
// sample    in         sample_valid / sample_stall mwo_pkg::sample_t
// pose      out        pose_valid / pose_stall     mwo_pkg::pose_t
// apb       in/out     psel, penable, pwrite       paddr, pwdata, prdata
//
// An encoder sample passes through the back sequencer and gives no result.
// An odometry tick holds the sequencer until the 32-step square root, started in state
// ST_SQ2, is done; the CORDIC loop ends earlier.
// The front queue holds two requests; sample_stall rises only when it is full.
// The result register holds one pose; the sequencer waits while it is stalled.
// Reset clears the wheel state, the pose accumulators and the registers to defaults.
`timescale 1ns / 1ps
`include "mecanum_wheel_odometry_defines.svh"
module mecanum_wheel_odometry #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  mwo_pkg::sample_t sample,
	output logic             pose_valid,
	input  logic             pose_stall,
	output mwo_pkg::pose_t   pose,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mwo_pkg::*;

	cfg_t    cfg_q;
	q_head_t q_head;
	logic    pop;
	logic    res_valid, res_take;
	pose_t   res;
	logic    pose_valid_q;
	pose_t   pose_q;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_gain <= 32'd65536;
			cfg_q.rim_radius <= 16'd3277;
			cfg_q.inv_half_base_sum <= 24'd262144;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SPEED_GAIN:   cfg_q.speed_gain <= pwdata;
				REG_RIM_RADIUS:   cfg_q.rim_radius <= pwdata[15:0];
				REG_INV_HALF_SUM: cfg_q.inv_half_base_sum <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SPEED_GAIN:   prdata = cfg_q.speed_gain;
			REG_RIM_RADIUS:   prdata = {16'b0, cfg_q.rim_radius};
			REG_INV_HALF_SUM: prdata = {8'b0, cfg_q.inv_half_base_sum};
			default:          prdata = '0;
		endcase
	end

	mwo_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.head(q_head),
		.pop(pop)
	);

	mwo_back #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(q_head),
		.pop(pop),
		.res_valid(res_valid),
		.res(res),
		.res_take(res_take)
	);

	// load the result register when it is empty or draining
	assign res_take = res_valid && (!pose_valid_q || !pose_stall);

	always_ff @(posedge clk) begin
		if (res_take) begin
			pose_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_valid_q <= 1'b0;
		end else if (res_take) begin
			pose_valid_q <= 1'b1;
		end else if (!pose_stall) begin
			pose_valid_q <= 1'b0;
		end
	end

	assign pose_valid = pose_valid_q;
	assign pose = pose_q;

	`MWO_ASSERT_IMPL(a_heading_range, pose_valid, pose.heading <= TWO_PI_Q29, "heading above 2*pi")
	`MWO_ASSERT_IMPL(a_pop_nonempty, pop, q_head.avail, "pop from empty queue")
	`MWO_ASSERT_NEXT(a_take_loads, res_take, pose_valid, "result not loaded")

endmodule

FILE: rtl/mwo_front.sv
// Front end: takes requests and holds them in a two-entry queue for the back end.
`timescale 1ns / 1ps
module mwo_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  mwo_pkg::sample_t  sample,
	output mwo_pkg::q_head_t  head,
	input  logic              pop
);
	import mwo_pkg::*;

	sample_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign sample_stall = (count_q == 2'd2);
	assign push = sample_valid && !sample_stall;
	assign head.avail = (count_q != 2'd0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/mwo_cordic.sv
// Iterative CORDIC: cos and sin of a Q3.29 heading, one rotation per cycle.
`timescale 1ns / 1ps
module mwo_cordic #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [32:0] cos_val,
	output logic signed [32:0] sin_val
);
	import mwo_pkg::*;

	localparam int STEP_W = $clog2(CORDIC_STEPS);

	logic signed [32:0] x_q, y_q;
	logic signed [34:0] z_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q, done_q, flip_q;
	logic signed [34:0] z0, z1;
	logic               flip0;
	logic signed [32:0] xs, ys;
	logic signed [34:0] at;

	always_comb begin
		z0 = $signed({2'b00, angle, 1'b0});
		if (z0 > PI_Q30) begin
			z0 = z0 - TWO_PI_Q30;
		end
		z1 = z0;
		flip0 = 1'b0;
		if (z0 > HALF_PI_Q30) begin
			z1 = z0 - PI_Q30;
			flip0 = 1'b1;
		end else if (z0 < -HALF_PI_Q30) begin
			z1 = z0 + PI_Q30;
			flip0 = 1'b1;
		end
	end

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = $signed({3'b000, atan_q30(5'(step_q))});

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= z1;
			flip_q <= flip0;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			step_q <= step_q + 1'b1;
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

FILE: rtl/mwo_isqrt.sv
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
`timescale 1ns / 1ps
module mwo_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [30:0] root
);
	logic [63:0] rem_q, root_q, bit_q;
	logic [4:0]  iter_q;
	logic        busy_q, done_q;
	logic [64:0] trial;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			root_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= rem_q - trial[63:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (busy_q) begin
			if (iter_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			iter_q <= iter_q + 5'd1;
		end
	end

	assign done = done_q;
	// saturate to the 31-bit output range
	assign root = (root_q[63:31] != '0) ? 31'h7FFF_FFFF : root_q[30:0];

endmodule

FILE: rtl/mwo_back.sv
// Back end: sequencer with one shared multiplier for encoder updates and odometry ticks.
`timescale 1ns / 1ps
module mwo_back #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mwo_pkg::cfg_t     cfg,
	input  mwo_pkg::q_head_t  head,
	output logic              pop,
	output logic              res_valid,
	output mwo_pkg::pose_t    res,
	input  logic              res_take
);
	import mwo_pkg::*;

	typedef enum logic [20:0] {
		ST_IDLE    = 21'h000001,
		ST_ENC_MUL = 21'h000002,
		ST_ENC_WR  = 21'h000004,
		ST_SUM     = 21'h000008,
		ST_MX      = 21'h000010,
		ST_MY      = 21'h000020,
		ST_MW      = 21'h000040,
		ST_MZ      = 21'h000080,
		ST_WZ      = 21'h000100,
		ST_SQ1     = 21'h000200,
		ST_SQ2     = 21'h000400,
		ST_HEAD    = 21'h000800,
		ST_CWAIT   = 21'h001000,
		ST_C1      = 21'h002000,
		ST_C2      = 21'h004000,
		ST_C3      = 21'h008000,
		ST_C4      = 21'h010000,
		ST_C5      = 21'h020000,
		ST_C6      = 21'h040000,
		ST_C7      = 21'h080000,
		ST_DONE    = 21'h100000
	} state_t;

	state_t state_q, state_d;

	sample_t            cur_q;
	logic [31:0]        last_count_q [WHEEL_COUNT];
	logic signed [31:0] wheel_rate_q [WHEEL_COUNT];
	logic signed [31:0] acc_x_q, acc_y_q;
	logic [31:0]        acc_heading_q;
	logic signed [33:0] sx_q, sy_q, sw_q;
	logic signed [31:0] vx_q, vy_q, wz_q;
	logic signed [33:0] wx_q, wy_q;
	logic signed [66:0] prod_q, tmp_q;
	logic [63:0]        sq_q;

	logic signed [33:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [66:0] prod_d;
	logic signed [32:0] dt_s, radius_s;
	logic signed [31:0] delta;
	logic signed [33:0] w0, w1, w2, w3;
	logic signed [46:0] h_raw, h_wrap, h_fin;

	logic               cordic_done, sqrt_done;
	logic signed [32:0] cos_val, sin_val;
	logic [30:0]        mag;

	assign dt_s = $signed({17'b0, cur_q.time_step});
	assign radius_s = $signed({17'b0, cfg.rim_radius});
	assign delta = $signed(cur_q.abs_count - $signed(last_count_q[cur_q.wheel_index]));

	assign w0 = 34'(wheel_rate_q[0]);
	assign w1 = 34'(wheel_rate_q[1]);
	assign w2 = 34'(wheel_rate_q[2]);
	assign w3 = 34'(wheel_rate_q[3]);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ENC_MUL: begin
				mul_a = 34'(delta);
				mul_b = $signed({1'b0, cfg.speed_gain});
			end
			ST_MX: begin
				mul_a = sx_q;
				mul_b = radius_s;
			end
			ST_MY: begin
				mul_a = sy_q;
				mul_b = radius_s;
			end
			ST_MW: begin
				mul_a = sw_q;
				mul_b = radius_s;
			end
			ST_MZ: begin
				mul_a = 34'(prod_q >>> 18);
				mul_b = $signed({9'b0, cfg.inv_half_base_sum});
			end
			ST_WZ: begin
				mul_a = 34'(vx_q);
				mul_b = 33'(vx_q);
			end
			ST_SQ1: begin
				mul_a = 34'(vy_q);
				mul_b = 33'(vy_q);
			end
			ST_SQ2: begin
				mul_a = 34'(wz_q);
				mul_b = dt_s;
			end
			ST_C1: begin
				mul_a = 34'(vx_q);
				mul_b = cos_val;
			end
			ST_C2: begin
				mul_a = 34'(vy_q);
				mul_b = sin_val;
			end
			ST_C3: begin
				mul_a = 34'(vx_q);
				mul_b = sin_val;
			end
			ST_C4: begin
				mul_a = 34'(vy_q);
				mul_b = cos_val;
			end
			ST_C5: begin
				mul_a = wx_q;
				mul_b = dt_s;
			end
			ST_C6: begin
				mul_a = wy_q;
				mul_b = dt_s;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// heading step, one wrap of 2*pi, then clamp
	always_comb begin
		h_raw = $signed({15'b0, acc_heading_q}) + 47'(prod_q >>> 3);
		if (h_raw > $signed({15'b0, TWO_PI_Q29})) begin
			h_wrap = h_raw - $signed({15'b0, TWO_PI_Q29});
		end else if (h_raw < 0) begin
			h_wrap = h_raw + $signed({15'b0, TWO_PI_Q29});
		end else begin
			h_wrap = h_raw;
		end
		h_fin = h_wrap;
		if (h_wrap < 0) begin
			h_fin = '0;
		end else if (h_wrap > $signed({15'b0, TWO_PI_Q29})) begin
			h_fin = $signed({15'b0, TWO_PI_Q29});
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head.avail) begin
					state_d = head.entry.mode ? ST_SUM : ST_ENC_MUL;
				end
			end
			ST_ENC_MUL: state_d = ST_ENC_WR;
			ST_ENC_WR:  state_d = ST_IDLE;
			ST_SUM:     state_d = ST_MX;
			ST_MX:      state_d = ST_MY;
			ST_MY:      state_d = ST_MW;
			ST_MW:      state_d = ST_MZ;
			ST_MZ:      state_d = ST_WZ;
			ST_WZ:      state_d = ST_SQ1;
			ST_SQ1:     state_d = ST_SQ2;
			ST_SQ2:     state_d = ST_HEAD;
			ST_HEAD:    state_d = ST_CWAIT;
			ST_CWAIT: begin
				if (cordic_done) begin
					state_d = ST_C1;
				end
			end
			ST_C1:      state_d = ST_C2;
			ST_C2:      state_d = ST_C3;
			ST_C3:      state_d = ST_C4;
			ST_C4:      state_d = ST_C5;
			ST_C5:      state_d = ST_C6;
			ST_C6:      state_d = ST_C7;
			ST_C7:      state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	assign pop = (state_q == ST_IDLE) && head.avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (pop) begin
			cur_q <= head.entry;
		end
		case (state_q)
			ST_SUM: begin
				sx_q <= w0 + w1 + w2 + w3;
				sy_q <= -w0 + w1 + w2 - w3;
				sw_q <= -w0 + w1 - w2 + w3;
			end
			ST_MY: vx_q <= sat32(prod_q >>> 18);
			ST_MW: vy_q <= sat32(prod_q >>> 18);
			ST_WZ: wz_q <= sat32(prod_q >>> 16);
			ST_SQ1: sq_q <= prod_q[63:0];
			ST_C2: tmp_q <= prod_q;
			ST_C3: wx_q <= 34'((tmp_q - prod_q) >>> 30);
			ST_C4: tmp_q <= prod_q;
			ST_C5: wy_q <= 34'((tmp_q + prod_q) >>> 30);
			default: begin
			end
		endcase
	end

	// persistent odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				last_count_q[i] <= '0;
				wheel_rate_q[i] <= '0;
			end
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_heading_q <= '0;
		end else begin
			case (state_q)
				ST_ENC_MUL: last_count_q[cur_q.wheel_index] <= cur_q.abs_count;
				ST_ENC_WR: wheel_rate_q[cur_q.wheel_index] <= sat32(prod_q >>> 16);
				ST_HEAD: acc_heading_q <= h_fin[31:0];
				ST_C6: acc_x_q <= sat32(67'(acc_x_q) + (prod_q >>> 16));
				ST_C7: acc_y_q <= sat32(67'(acc_y_q) + (prod_q >>> 16));
				default: begin
				end
			endcase
		end
	end

	// cordic latches the pre-tick heading at start
	mwo_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_SUM),
		.angle(acc_heading_q),
		.done(cordic_done),
		.cos_val(cos_val),
		.sin_val(sin_val)
	);

	mwo_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_SQ2),
		.radicand(sq_q + prod_q[63:0]),
		.done(sqrt_done),
		.root(mag)
	);

	assign res_valid = (state_q == ST_DONE) && sqrt_done;
	assign res.pos_x = acc_x_q;
	assign res.pos_y = acc_y_q;
	assign res.heading = acc_heading_q;
	assign res.vel_x = vx_q;
	assign res.vel_y = vy_q;
	assign res.yaw_rate = wz_q;
	assign res.speed_magnitude = mag;

endmodule
